[sv/bpbi_pkg.sv]
package bpbi_pkg;

  localparam int MAX_LEVELS = 10;
  localparam int COORD_W    = 24;
  localparam int BIN_W      = 10;
  localparam int LEVEL_W    = 4;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_MAX_X  = 3'd3,
    REG_MAX_Y  = 3'd4,
    REG_MAX_Z  = 3'd5,
    REG_LEVELS = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // ext: box extent per axis, room: box upper bound minus point per axis
  typedef struct packed {
    logic [2:0][COORD_W-1:0] ext;
    logic [2:0][COORD_W-1:0] room;
    logic [LEVEL_W-1:0]      levels;
    logic                    in_box;
    logic [BIN_W-1:0]        bin;
  } stage_t;

endpackage

[sv/bpbi_level.sv]
module bpbi_level
  import bpbi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [LEVEL_W-1:0] lvl_i,
  input  logic               valid_i,
  input  stage_t             data_i,
  output logic               valid_o,
  output stage_t             data_o
);

  logic                    valid_q;
  stage_t                  data_q;
  stage_t                  data_d;
  axis_e                   axis;
  logic                    active;
  logic [2:0][COORD_W-1:0] half;
  logic [2:0]              lower;
  logic                    sel_lower;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      half[a]  = data_i.ext[a] >> 1;
      lower[a] = data_i.room[a] >= half[a];
    end
  end

  // ties: y over x, z over y
  always_comb begin
    if (data_i.ext[0] > data_i.ext[1]) begin
      axis = (data_i.ext[0] > data_i.ext[2]) ? AXIS_X : AXIS_Z;
    end else begin
      axis = (data_i.ext[1] > data_i.ext[2]) ? AXIS_Y : AXIS_Z;
    end
  end

  always_comb begin
    unique case (axis)
      AXIS_X:  sel_lower = lower[0];
      AXIS_Y:  sel_lower = lower[1];
      AXIS_Z:  sel_lower = lower[2];
      default: sel_lower = lower[2];
    endcase
  end

  assign active = data_i.in_box && (lvl_i < data_i.levels);

  // both children keep extent e - floor(e/2); only the lower one moves hi
  always_comb begin
    data_d = data_i;
    if (active) begin
      for (int a = 0; a < 3; a++) begin
        if (axis == axis_e'(a)) begin
          data_d.ext[a] = data_i.ext[a] - half[a];
          if (lower[a]) begin
            data_d.room[a] = data_i.room[a] - half[a];
          end
        end
      end
      data_d.bin = {data_i.bin[BIN_W-2:0], ~sel_lower};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/box_partition_bin_index.sv]
// Channel | Direction | Handshake                 | Payload
// cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i / in_stall_o   | point_x_i, point_y_i, point_z_i
// out     | out       | out_valid_o / out_stall_i | bin_index_o, inside_root_o
//
// One vertex enters per cycle while in_stall_o is low; the pipeline is one bounds-check
// stage, then one register stage per halving level, the last one driving the outputs.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled output freezes only the full stages behind it.
// Reset clears valid bits and configuration registers; cfg_ready_o is always high.
module box_partition_bin_index
  import bpbi_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COORD_W-1:0]          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [COORD_W-1:0]   point_x_i,
  input  logic signed [COORD_W-1:0]   point_y_i,
  input  logic signed [COORD_W-1:0]   point_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [BIN_W-1:0]            bin_index_o,
  output logic                        inside_root_o
);

  localparam int N = MAX_LEVELS;

  logic signed [2:0][COORD_W-1:0] min_q;
  logic signed [2:0][COORD_W-1:0] max_q;
  logic [LEVEL_W-1:0]             levels_q;

  logic [2:0][COORD_W-1:0]        pt;
  logic                           s0_v_q;
  stage_t                         s0_q;
  stage_t                         s0_d;

  logic                           stg_v [0:N];
  stage_t                         stg   [0:N];
  logic                           en    [0:N];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= '0;
      levels_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MIN_X:  min_q[0] <= cfg_data_i;
        REG_MIN_Y:  min_q[1] <= cfg_data_i;
        REG_MIN_Z:  min_q[2] <= cfg_data_i;
        REG_MAX_X:  max_q[0] <= cfg_data_i;
        REG_MAX_Y:  max_q[1] <= cfg_data_i;
        REG_MAX_Z:  max_q[2] <= cfg_data_i;
        REG_LEVELS: levels_q <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    s0_d.in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if ($signed(pt[a]) < $signed(min_q[a]) || $signed(pt[a]) > $signed(max_q[a])) begin
        s0_d.in_box = 1'b0;
      end
      s0_d.ext[a]  = max_q[a] - min_q[a];
      s0_d.room[a] = max_q[a] - pt[a];
    end
    s0_d.levels = (levels_q > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : levels_q;
    s0_d.bin    = '0;
  end

  always_comb begin
    en[N] = !stg_v[N] || !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !stg_v[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en[0]) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= s0_d;
    end
  end

  assign stg_v[0] = s0_v_q;
  assign stg[0]   = s0_q;

  for (genvar g = 0; g < N; g++) begin : g_level
    bpbi_level u_level (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g+1]),
      .lvl_i   (LEVEL_W'(g)),
      .valid_i (stg_v[g]),
      .data_i  (stg[g]),
      .valid_o (stg_v[g+1]),
      .data_o  (stg[g+1])
    );
  end

  assign out_valid_o   = stg_v[N];
  assign bin_index_o   = stg[N].in_box ? stg[N].bin : '0;
  assign inside_root_o = stg[N].in_box;

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_root_o |-> bin_index_o == '0)
    else $error("outside point with nonzero bin");

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_v_q && out_valid_o && out_stall_i)
    else $error("input stalled with room in pipeline");

endmodule
